/* hw/rtl/vnn_pkg.sv */
package vnn_pkg;

  // default vertex store depth
  localparam int MAX_VERTICES_DEF = 1024;

  // widths fixed by the item fields
  localparam int IDX_W = 10;
  localparam int POS_W = 16;
  localparam int DIF_W = 17;
  localparam int SUM_W = 35;
  localparam int NRM_W = 16;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_NORMAL = 1'b1;

  typedef struct packed {
    logic                    cmd;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0]        first_neighbor;
    logic [IDX_W-1:0]        second_neighbor;
    logic [IDX_W-1:0]        third_neighbor;
    logic [IDX_W-1:0]        fourth_neighbor;
  } in_item_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    degenerate;
  } out_item_t;

  // summed cross product handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] s_x;
    logic signed [SUM_W-1:0] s_y;
    logic signed [SUM_W-1:0] s_z;
  } sum_t;

endpackage

/* hw/rtl/vnn_front.sv */
module vnn_front
  import vnn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     job_push,
  input  logic     job_full,
  output sum_t     job
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MAC, S_PUSH} state_t;

  state_t                  state;
  logic [2:0]              rd_cnt;
  logic [2:0]              rd_sel;
  logic [3:0]              mac_cnt;
  logic                    rd_ok;
  logic [IDX_W-1:0]        idx_q [5];
  logic [3*POS_W-1:0]      mem [MAX_VERTICES];
  logic [3*POS_W-1:0]      rdata;
  logic [3*POS_W-1:0]      pos;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we;
  logic                    accept;
  logic signed [POS_W-1:0] ctr [3];
  logic signed [DIF_W-1:0] d [4][3];
  logic signed [SUM_W-1:0] acc [3];
  logic [1:0]              comp, ca, cb, cu, cv;
  logic                    pair, swap;
  logic signed [2*DIF_W-1:0] prod;

  assign full   = (state != S_IDLE);
  assign accept = push && !full;
  assign rd_sel = (rd_cnt < 3'd5) ? rd_cnt : 3'd4;
  assign mem_we = accept && (item.cmd == CMD_WRITE) &&
                  (32'(item.vertex_index) < MAX_VERTICES);
  assign mem_addr = (state == S_READ) ? AW'(idx_q[rd_sel]) : AW'(item.vertex_index);

  // single-port vertex store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {item.pos_x, item.pos_y, item.pos_z};
    end else begin
      rdata <= mem[mem_addr];
    end
  end

  // out-of-range reads give the origin
  assign pos = rd_ok ? rdata : '0;

  // term selection for the multiply-accumulate sequence
  assign comp = mac_cnt[3:2];
  assign pair = mac_cnt[1];
  assign swap = mac_cnt[0];
  always_comb begin
    case (comp)
      2'd0:    begin ca = 2'd1; cb = 2'd2; end
      2'd1:    begin ca = 2'd2; cb = 2'd0; end
      default: begin ca = 2'd0; cb = 2'd1; end
    endcase
    cu = swap ? cb : ca;
    cv = swap ? ca : cb;
  end
  assign prod = d[{pair, 1'b0}][cu] * d[{pair, 1'b1}][cv];

  assign job_push = (state == S_PUSH);
  assign job = '{s_x: acc[0], s_y: acc[1], s_z: acc[2]};

  // sequencer: gather five positions, then twelve product terms
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_cnt  <= '0;
      mac_cnt <= '0;
      rd_ok   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && item.cmd == CMD_NORMAL) begin
            idx_q[0] <= item.vertex_index;
            idx_q[1] <= item.first_neighbor;
            idx_q[2] <= item.second_neighbor;
            idx_q[3] <= item.third_neighbor;
            idx_q[4] <= item.fourth_neighbor;
            rd_cnt   <= '0;
            state    <= S_READ;
          end
        end
        S_READ: begin
          rd_ok <= (32'(idx_q[rd_sel]) < MAX_VERTICES);
          if (rd_cnt == 3'd1) begin
            ctr[0] <= pos[47:32];
            ctr[1] <= pos[31:16];
            ctr[2] <= pos[15:0];
          end else if (rd_cnt != 3'd0) begin
            d[2'(rd_cnt - 3'd2)][0] <= DIF_W'(signed'(pos[47:32])) - DIF_W'(ctr[0]);
            d[2'(rd_cnt - 3'd2)][1] <= DIF_W'(signed'(pos[31:16])) - DIF_W'(ctr[1]);
            d[2'(rd_cnt - 3'd2)][2] <= DIF_W'(signed'(pos[15:0])) - DIF_W'(ctr[2]);
          end
          if (rd_cnt == 3'd5) begin
            mac_cnt <= '0;
            acc[0]  <= '0;
            acc[1]  <= '0;
            acc[2]  <= '0;
            state   <= S_MAC;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        S_MAC: begin
          acc[comp] <= swap ? acc[comp] - SUM_W'(prod) : acc[comp] + SUM_W'(prod);
          if (mac_cnt == 4'd11) begin
            state <= S_PUSH;
          end else begin
            mac_cnt <= mac_cnt + 4'd1;
          end
        end
        S_PUSH: begin
          if (!job_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/vnn_queue.sv */
module vnn_queue
  import vnn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  sum_t wdata,
  input  logic pop,
  output logic empty,
  output sum_t rdata
);

  sum_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* hw/rtl/vnn_back.sv */
module vnn_back
  import vnn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_empty,
  output logic      job_pop,
  input  sum_t      job,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  typedef enum logic [2:0] {S_IDLE, S_SQUARE, S_ROOT, S_DIVIDE, S_DONE} state_t;

  state_t            state;
  logic              out_valid;
  out_item_t         res_q;
  out_item_t         res_w;
  logic [30:0]       mag [3];
  logic              neg [3];
  logic [1:0]        comp;
  logic [4:0]        step;
  logic [3:0]        qbit;
  logic [63:0]       sum;
  logic [63:0]       rv, rr, rbit;
  logic [31:0]       len;
  logic [46:0]       rem;
  logic [15:0]       quo;
  logic [34:0]       ax, ay, az, mx;
  logic [2:0]        sh;
  logic [63:0]       rtry;
  logic [46:0]       dtry;
  logic [15:0]       qnext;
  logic [31:0]       len_fix;
  logic [1:0]        cnext;

  assign empty   = !out_valid;
  assign result  = res_q;
  assign job_pop = (state == S_IDLE) && !job_empty;

  // magnitudes and the shift that brings the largest below 2^31
  always_comb begin
    ax = job.s_x[SUM_W-1] ? 35'(-job.s_x) : 35'(job.s_x);
    ay = job.s_y[SUM_W-1] ? 35'(-job.s_y) : 35'(job.s_y);
    az = job.s_z[SUM_W-1] ? 35'(-job.s_z) : 35'(job.s_z);
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;
    if (mx[34])      sh = 3'd4;
    else if (mx[33]) sh = 3'd3;
    else if (mx[32]) sh = 3'd2;
    else if (mx[31]) sh = 3'd1;
    else             sh = 3'd0;
  end

  assign rtry    = rr + rbit;
  assign len_fix = (rr[31:0] == 32'd0) ? 32'd1 : rr[31:0];
  assign dtry    = 47'(len) << qbit;
  assign qnext   = (rem >= dtry) ? (quo | (16'd1 << qbit)) : quo;
  assign cnext   = (comp == 2'd2) ? 2'd2 : comp + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      comp      <= '0;
      qbit      <= '0;
    end else begin
      if (pop && out_valid && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            neg[0] <= job.s_x[SUM_W-1];
            neg[1] <= job.s_y[SUM_W-1];
            neg[2] <= job.s_z[SUM_W-1];
            mag[0] <= 31'(ax >> sh);
            mag[1] <= 31'(ay >> sh);
            mag[2] <= 31'(az >> sh);
            sum    <= '0;
            comp   <= '0;
            if (mx == 35'd0) begin
              res_w.normal_x   <= '0;
              res_w.normal_y   <= '0;
              res_w.normal_z   <= '0;
              res_w.degenerate <= 1'b1;
              state            <= S_DONE;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          sum <= sum + 64'(mag[comp] * mag[comp]);
          if (comp == 2'd2) begin
            comp  <= '0;
            step  <= '0;
            rr    <= '0;
            rbit  <= 64'd1 << 62;
            rv    <= sum + 64'(mag[comp] * mag[comp]);
            state <= S_ROOT;
          end else begin
            comp <= comp + 2'd1;
          end
        end
        S_ROOT: begin
          // one digit of the integer square root per cycle
          if (rv >= rtry) begin
            rv <= rv - rtry;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
          step <= step + 5'd1;
          if (step == 5'd31) begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (step == 5'd0) begin
            // first cycle: fix the length and load the first dividend
            len   <= len_fix;
            rem   <= 47'({mag[0], 14'd0}) + 47'(len_fix >> 1);
            quo   <= '0;
            qbit  <= 4'd15;
            step  <= 5'd1;
          end else begin
            if (qbit != 4'd0) begin
              if (rem >= dtry) rem <= rem - dtry;
              quo  <= qnext;
              qbit <= qbit - 4'd1;
            end else begin
              case (comp)
                2'd0:    res_w.normal_x <= neg[0] ? -qnext : qnext;
                2'd1:    res_w.normal_y <= neg[1] ? -qnext : qnext;
                default: res_w.normal_z <= neg[2] ? -qnext : qnext;
              endcase
              res_w.degenerate <= 1'b0;
              rem  <= 47'({mag[cnext], 14'd0}) + 47'(len >> 1);
              quo  <= '0;
              qbit <= 4'd15;
              comp <= cnext;
              if (comp == 2'd2) state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // hand over once the output register is free or being popped
          if (!out_valid || pop) begin
            res_q     <= res_w;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.degenerate) |->
      (res_q.normal_x == 0 && res_q.normal_y == 0 && res_q.normal_z == 0))
    else $error("degenerate result with non-zero normal");
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res_q.degenerate) |->
      (res_q.normal_x <= 16384 && res_q.normal_x >= -16384 &&
       res_q.normal_y <= 16384 && res_q.normal_y >= -16384 &&
       res_q.normal_z <= 16384 && res_q.normal_z >= -16384))
    else $error("normal component beyond unit length");
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE && step != 5'd0) |-> (64'(len) * 64'(len) <= sum))
    else $error("square root exceeds its argument");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQUARE) |-> $past(state) == S_IDLE || $past(state) == S_SQUARE)
    else $error("squaring entered without a job");
`endif

endmodule

/* hw/rtl/vertex_normal_from_neighbors_unit.sv */
// Vertex normal unit.
// Input channel (push/full, item): cmd 0 writes a Q8.8 x,y,z position into
// the vertex store; cmd 1 names a centre vertex and four neighbours and
// asks for the normal of (d0 x d1 + d2 x d3), d = neighbour - centre.
// Result channel (empty/pop, result): one Q1.14 unit normal per compute
// item, in order, with the degenerate flag set and a zero normal when the
// summed cross product is zero. Write items give no result.
// Writes are taken one per cycle while the front is idle. A compute item
// holds the front through reads of five positions from the single-port
// vertex store and twelve terms on the shared multiply-accumulate, then a
// transfer into a two-entry queue. The back end works through three
// squarings, 32 root steps, a length fix and three 16-step divides, then
// a hand-over and a return to idle (a zero sum goes straight to the
// hand-over), and takes no new job from the queue until it is idle again.
// Reset clears the control state; the vertex store is not cleared and its
// entries must be written before they are read.
// A stalled receiver holds the result; the back end then stops at its
// end, the queue fills and full rises to hold the input side.
module vertex_normal_from_neighbors_unit
  import vnn_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic job_push, job_full, job_pop, job_empty;
  sum_t job_in, job_out;

  vnn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_in)
  );

  vnn_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_in),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_out)
  );

  vnn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import vnn_pkg::*;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  vertex_normal_from_neighbors_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  // shadow of the vertex store and which entries hold a position
  logic signed [POS_W-1:0] shadow_x [1024];
  logic signed [POS_W-1:0] shadow_y [1024];
  logic signed [POS_W-1:0] shadow_z [1024];
  bit                      written [1024];
  int                      written_list [$];

  out_item_t normal_queue [$];
  int        fail_count = 0;
  bit        idle_on = 1;
  bit        pop_stall_on = 1;
  bit        stim_done = 0;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } table_row_t;

  table_row_t dir_table [$];

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit normal of d0 x d1 + d2 x d3 in Q1.14
  function automatic out_item_t calc_vertex_normal(in_item_t it);
    longint          cx, cy, cz, s [3];
    longint          dx [4], dy [4], dz [4];
    longint unsigned mag [3], mx, sq, len, q;
    int              nb [4], sh;
    out_item_t       o;
    nb[0] = it.first_neighbor;
    nb[1] = it.second_neighbor;
    nb[2] = it.third_neighbor;
    nb[3] = it.fourth_neighbor;
    cx = shadow_x[it.vertex_index];
    cy = shadow_y[it.vertex_index];
    cz = shadow_z[it.vertex_index];
    for (int k = 0; k < 4; k++) begin
      dx[k] = longint'(shadow_x[nb[k]]) - cx;
      dy[k] = longint'(shadow_y[nb[k]]) - cy;
      dz[k] = longint'(shadow_z[nb[k]]) - cz;
    end
    s[0] = (dy[0] * dz[1] - dz[0] * dy[1]) + (dy[2] * dz[3] - dz[2] * dy[3]);
    s[1] = (dz[0] * dx[1] - dx[0] * dz[1]) + (dz[2] * dx[3] - dx[2] * dz[3]);
    s[2] = (dx[0] * dy[1] - dy[0] * dx[1]) + (dx[2] * dy[3] - dy[2] * dx[3]);
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = s[i] < 0 ? longint'(-s[i]) : s[i];
      if (mag[i] > mx) mx = mag[i];
    end
    o = '0;
    if (mx == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    sh = 0;
    while ((mx >> sh) >= (64'd1 << 31)) sh++;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sq += mag[i] * mag[i];
    end
    len = int_sqrt(sq);
    if (len == 0) len = 1;
    q = (mag[0] * 16384 + len / 2) / len;
    o.normal_x = s[0] < 0 ? -q[15:0] : q[15:0];
    q = (mag[1] * 16384 + len / 2) / len;
    o.normal_y = s[1] < 0 ? -q[15:0] : q[15:0];
    q = (mag[2] * 16384 + len / 2) / len;
    o.normal_z = s[2] < 0 ? -q[15:0] : q[15:0];
    return o;
  endfunction

  function automatic in_item_t make_write(int idx, int x, int y, int z);
    in_item_t it;
    it = '0;
    it.cmd = CMD_WRITE;
    it.vertex_index = IDX_W'(idx);
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.pos_z = POS_W'(z);
    return it;
  endfunction

  function automatic in_item_t make_normal(int c, int a, int b, int e, int f);
    in_item_t it;
    it = '0;
    it.cmd = CMD_NORMAL;
    it.vertex_index = IDX_W'(c);
    it.first_neighbor = IDX_W'(a);
    it.second_neighbor = IDX_W'(b);
    it.third_neighbor = IDX_W'(e);
    it.fourth_neighbor = IDX_W'(f);
    return it;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 1024)) - 512;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rand_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // overall limit
  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  // prediction on each accepted transfer
  task automatic record_item(in_item_t it, bit typed, out_item_t want);
    if (it.cmd == CMD_WRITE) begin
      shadow_x[it.vertex_index] = it.pos_x;
      shadow_y[it.vertex_index] = it.pos_y;
      shadow_z[it.vertex_index] = it.pos_z;
      if (!written[it.vertex_index]) written_list.push_back(it.vertex_index);
      written[it.vertex_index] = 1;
    end else begin
      normal_queue.push_back(typed ? want : calc_vertex_normal(it));
    end
  endtask

  // drive one item and hold it until transferred
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    record_item(it, typed, want);
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    out_item_t none, w;
    in_item_t  it;
    int        c;
    none = '0;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    dir_table.push_back('{make_write(0, 0, 0, 0), 0, none});
    dir_table.push_back('{make_write(1, 256, 0, 0), 0, none});
    dir_table.push_back('{make_write(2, 0, 256, 0), 0, none});
    dir_table.push_back('{make_write(3, -32768, -32768, -32768), 0, none});
    dir_table.push_back('{make_write(4, 32767, 32767, 32767), 0, none});
    dir_table.push_back('{make_write(1023, 32767, -32768, 0), 0, none});
    w = '0; w.normal_z = 16384;
    dir_table.push_back('{make_normal(0, 1, 2, 1, 2), 1, w});
    w = '0; w.degenerate = 1'b1;
    dir_table.push_back('{make_normal(0, 0, 0, 0, 0), 1, w});
    w = '0; w.normal_z = -16384;
    dir_table.push_back('{make_normal(0, 2, 1, 0, 0), 1, w});
    dir_table.push_back('{make_normal(3, 4, 1023, 1023, 4), 0, none});
    dir_table.push_back('{make_normal(1023, 3, 4, 0, 1), 0, none});
    // write with neighbour fields all ones: they must be ignored
    it = make_write(5, -32768, 32767, -1);
    it.first_neighbor = '1; it.second_neighbor = '1;
    it.third_neighbor = '1; it.fourth_neighbor = '1;
    dir_table.push_back('{it, 0, none});
    // compute with position fields all ones: they must be ignored
    it = make_normal(4, 3, 1023, 0, 5);
    it.pos_x = '1; it.pos_y = '1; it.pos_z = '1;
    dir_table.push_back('{it, 0, none});
    // parallel edges and zero edges cancel out
    w = '0; w.degenerate = 1'b1;
    dir_table.push_back('{make_normal(4, 3, 3, 4, 4), 1, w});
    foreach (dir_table[i]) send_item(dir_table[i].it, dir_table[i].typed, dir_table[i].want);

    // random part
    for (int n = 0; n < 1300; n++) begin
      if (n % 150 == 0) idle_on = (n % 300 != 0);
      if (n == 650) begin
        // hold off until the result side has drained
        push <= 1'b0;
        while (normal_queue.size() != 0) @(negedge clk);
      end
      if (n < 60 || $urandom_range(0, 9) < 4) begin
        it = make_write($urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
        it.first_neighbor = IDX_W'($urandom); it.second_neighbor = IDX_W'($urandom);
        it.third_neighbor = IDX_W'($urandom); it.fourth_neighbor = IDX_W'($urandom);
      end else begin
        c = pick_written();
        if ($urandom_range(0, 9) == 0)
          it = make_normal(c, c, pick_written(), pick_written(), c);
        else
          it = make_normal(c, pick_written(), pick_written(), pick_written(),
                           pick_written());
        it.pos_x = POS_W'($urandom); it.pos_y = POS_W'($urandom);
        it.pos_z = POS_W'($urandom);
      end
      send_item(it, 0, none);
    end
    push <= 1'b0;
    stim_done = 1;
  end

  // result side stalls
  initial begin
    int hold;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop_stall_on = idle_on;
      if (pop_stall_on && $urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 3);
        pop <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (normal_queue.size() == 0) begin
        $error("result with nothing expected: %p", result);
        fail_count++;
      end else begin
        want = normal_queue.pop_front();
        if (result.normal_x !== want.normal_x) begin
          $error("normal_x expected %0d actual %0d", want.normal_x, result.normal_x);
          fail_count++;
        end
        if (result.normal_y !== want.normal_y) begin
          $error("normal_y expected %0d actual %0d", want.normal_y, result.normal_y);
          fail_count++;
        end
        if (result.normal_z !== want.normal_z) begin
          $error("normal_z expected %0d actual %0d", want.normal_z, result.normal_z);
          fail_count++;
        end
        if (result.degenerate !== want.degenerate) begin
          $error("degenerate expected %0b actual %0b", want.degenerate, result.degenerate);
          fail_count++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (normal_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && normal_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* vertex_normal_from_neighbors_unit.f */
hw/rtl/vnn_pkg.sv
hw/rtl/vnn_front.sv
hw/rtl/vnn_queue.sv
hw/rtl/vnn_back.sv
hw/rtl/vertex_normal_from_neighbors_unit.sv
tb/sv/tb.sv
